### sv/assert_macros.svh
// Assertion macros used by the port checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define U2I4DL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define U2I4DL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/u2i4dl_pkg.sv
// Package: shared types, codes and fixed widths of the dense-layer dot product
package u2i4dl_pkg;

  // Fixed field widths
  localparam int CFG_W        = 11;
  localparam int ACT_INDEX_W  = 8;
  localparam int PAYLOAD_W    = 16;
  localparam int ACT_BYTE_W   = 8;
  localparam int SUM_W        = 16;
  localparam int NEURON_IDX_W = 10;

  // Request command codes
  localparam logic CMD_LOAD_ACT = 1'b0;
  localparam logic CMD_WEIGHT   = 1'b1;

  // Register indexes on the configuration channel
  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic REG_NEURON_COUNT  = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] VECTOR_LENGTH_RST = 11'd4;
  localparam logic [CFG_W-1:0] NEURON_COUNT_RST  = 11'd1;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  // Controller to datapath
  typedef struct packed {
    logic act_write;    // store activation byte from the accepted request
    logic weight_load;  // latch weight word and read activation byte
    logic mac;          // accumulate the four products
    logic emit;         // neuron finished: register result, advance
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic word_last;    // current word is the last of this neuron
  } dp_status_t;

endpackage

### sv/u2i4dl_ctrl.sv
// Controller: request handshake and the two-state sequencer for weight words
module u2i4dl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic                   cmd_i,
  output logic                   busy,
  input  u2i4dl_pkg::dp_status_t status_i,
  output u2i4dl_pkg::ctrl_cmd_t  ctrl_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MAC  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign busy   = (state_q == ST_MAC);
  assign accept = start && !busy;

  // Command decode
  always_comb begin
    ctrl_o.act_write   = accept && (cmd_i == u2i4dl_pkg::CMD_LOAD_ACT);
    ctrl_o.weight_load = accept && (cmd_i == u2i4dl_pkg::CMD_WEIGHT);
    ctrl_o.mac         = (state_q == ST_MAC);
    ctrl_o.emit        = (state_q == ST_MAC) && status_i.word_last;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_o.weight_load) state_d = ST_MAC;
      end
      ST_MAC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/u2i4dl_datapath.sv
// Datapath: activation store, config registers, MAC, counters and result registers
module u2i4dl_datapath #(
  parameter int MAX_VECTOR_LENGTH = 1024,
  parameter int MAX_NEURONS       = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  u2i4dl_pkg::ctrl_cmd_t                  ctrl_i,
  output u2i4dl_pkg::dp_status_t                 status_o,
  input  logic [u2i4dl_pkg::ACT_INDEX_W-1:0]     act_index_i,
  input  logic [u2i4dl_pkg::PAYLOAD_W-1:0]       payload_i,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_index_i,
  input  logic [u2i4dl_pkg::CFG_W-1:0]           cfg_data_i,
  output logic                                   result_valid_o,
  output logic signed [u2i4dl_pkg::SUM_W-1:0]    neuron_sum_o,
  output logic [u2i4dl_pkg::NEURON_IDX_W-1:0]    neuron_index_o,
  output logic                                   last_neuron_o
);

  localparam int DEPTH  = MAX_VECTOR_LENGTH / 4;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NRN_W  = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int NCNT_W = $clog2(MAX_NEURONS + 1) + 1;
  localparam int SUM_W  = u2i4dl_pkg::SUM_W;

  // Configuration registers
  logic [u2i4dl_pkg::CFG_W-1:0] vector_length_q, neuron_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= u2i4dl_pkg::VECTOR_LENGTH_RST;
      neuron_count_q  <= u2i4dl_pkg::NEURON_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        u2i4dl_pkg::REG_VECTOR_LENGTH: vector_length_q <= cfg_data_i;
        u2i4dl_pkg::REG_NEURON_COUNT:  neuron_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped word count per neuron and neuron count per layer
  logic [u2i4dl_pkg::CFG_W-3:0] vl_words;
  logic [CNT_W-1:0]             words;
  logic [NCNT_W-1:0]            neurons;

  assign vl_words = vector_length_q[u2i4dl_pkg::CFG_W-1:2];

  always_comb begin
    if (vl_words == '0) begin
      words = CNT_W'(1);
    end else if (32'(vl_words) > DEPTH) begin
      words = CNT_W'(DEPTH);
    end else begin
      words = CNT_W'(vl_words);
    end
    if (neuron_count_q == '0) begin
      neurons = NCNT_W'(1);
    end else if (32'(neuron_count_q) > MAX_NEURONS) begin
      neurons = NCNT_W'(MAX_NEURONS);
    end else begin
      neurons = NCNT_W'(neuron_count_q);
    end
  end

  // Activation store: written on load requests, read at the word position
  logic [u2i4dl_pkg::ACT_BYTE_W-1:0] store_q [DEPTH];
  logic [u2i4dl_pkg::ACT_BYTE_W-1:0] act_q;
  logic [u2i4dl_pkg::PAYLOAD_W-1:0]  weight_q;
  logic [ADDR_W-1:0]                 wpos_q;
  logic                              slot_ok;

  assign slot_ok = (32'(act_index_i) < DEPTH);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.act_write && slot_ok) begin
      store_q[ADDR_W'(act_index_i)] <= payload_i[u2i4dl_pkg::ACT_BYTE_W-1:0];
    end
    if (ctrl_i.weight_load) begin
      act_q    <= store_q[wpos_q];
      weight_q <= payload_i;
    end
  end

  // Four 2-bit by 4-bit products, summed
  logic signed [3:0] w    [4];
  logic signed [6:0] prod [4];
  logic signed [8:0] mac_sum;

  always_comb begin
    mac_sum = '0;
    for (int k = 0; k < 4; k++) begin
      w[k]    = $signed(weight_q[4*k +: 4] & u2i4dl_pkg::NIBBLE_MASK);
      prod[k] = $signed({1'b0, act_q[2*k +: 2]}) * w[k];
      mac_sum = mac_sum + 9'(prod[k]);
    end
  end

  // Progress counters and accumulator
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  wpos_next;
  logic [NRN_W-1:0]  neuron_q;
  logic              layer_last;

  assign acc_d      = acc_q + SUM_W'(mac_sum);
  assign wpos_next  = CNT_W'(wpos_q) + CNT_W'(1);
  assign layer_last = (NCNT_W'(neuron_q) + NCNT_W'(1) >= neurons);

  assign status_o.word_last = (wpos_next >= words);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      wpos_q   <= '0;
      neuron_q <= '0;
    end else if (ctrl_i.emit) begin
      acc_q    <= '0;
      wpos_q   <= '0;
      neuron_q <= layer_last ? '0 : neuron_q + NRN_W'(1);
    end else if (ctrl_i.mac) begin
      acc_q    <= acc_d;
      wpos_q   <= ADDR_W'(wpos_next);
    end
  end

  // Result registers, strobe lasts one cycle
  logic                                 result_valid_q;
  logic [SUM_W-1:0]                     sum_q;
  logic [u2i4dl_pkg::NEURON_IDX_W-1:0]  index_q;
  logic                                 last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      sum_q   <= acc_d;
      index_q <= u2i4dl_pkg::NEURON_IDX_W'(neuron_q);
      last_q  <= layer_last;
    end
  end

  assign result_valid_o = result_valid_q;
  assign neuron_sum_o   = $signed(sum_q);
  assign neuron_index_o = index_q;
  assign last_neuron_o  = last_q;

endmodule

### sv/u2_i4_dense_layer_dot_product_top.sv
// Top level: dense-layer dot product of 2-bit activations and 4-bit weights
//
// Requests enter on start/busy: one is taken at each rising edge with start
// high and busy low. cmd_i = 0 writes payload_i[7:0] (four 2-bit activations)
// into activation slot act_index_i and never sets busy.
// cmd_i = 1 is a weight word for the current neuron: the activation byte is
// read from the store as it is taken, and busy is then high for one cycle
// while the four products are accumulated, so no request is taken until the
// MAC cycle is over, the pace set by the registered store read and the MAC
// cycle. After the last word of a neuron, result_valid_o pulses for one cycle,
// set from the MAC state, with neuron_sum_o, neuron_index_o and
// last_neuron_o. The receiver cannot stall; each result is shown once only.
// Configuration writes (cfg_valid_i, always ready) set vector_length (index 0)
// and neuron_count (index 1); issue them only while the block is idle.
// Reset clears progress, accumulator and strobe and presets the registers; the
// activation store is not cleared and must be written before it is read.
module u2_i4_dense_layer_dot_product_top #(
  parameter int MAX_VECTOR_LENGTH = 1024,
  parameter int MAX_NEURONS       = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic [u2i4dl_pkg::ACT_INDEX_W-1:0]  act_index_i,
  input  logic [u2i4dl_pkg::PAYLOAD_W-1:0]    payload_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [u2i4dl_pkg::CFG_W-1:0]        cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [u2i4dl_pkg::SUM_W-1:0] neuron_sum_o,
  output logic [u2i4dl_pkg::NEURON_IDX_W-1:0] neuron_index_o,
  output logic                                last_neuron_o
);

  u2i4dl_pkg::ctrl_cmd_t  ctrl;
  u2i4dl_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  u2i4dl_ctrl i_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .busy     (busy),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  u2i4dl_datapath #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH),
    .MAX_NEURONS       (MAX_NEURONS)
  ) i_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .act_index_i    (act_index_i),
    .payload_i      (payload_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .neuron_sum_o   (neuron_sum_o),
    .neuron_index_o (neuron_index_o),
    .last_neuron_o  (last_neuron_o)
  );

endmodule

### sv/u2i4dl_checker.sv
// Checker on the top-level ports, bound to the top level
`include "assert_macros.svh"

module u2i4dl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cmd_i,
  input logic result_valid_o
);

  logic load_req;
  logic busy_q;
  logic mac_done;

  // Activation load taken this cycle
  assign load_req = start && !busy && (cmd_i == u2i4dl_pkg::CMD_LOAD_ACT);

  // Busy level of the previous cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy;
    end
  end

  assign mac_done = busy_q && !busy;

  // A weight word occupies exactly one busy cycle
  `U2I4DL_ASSERT_NEXT(a_busy_one_cycle, clk_i, rst_ni, busy, !busy, "busy held over two cycles")

  // An activation load never makes the block busy
  `U2I4DL_ASSERT_NEXT(a_load_no_busy, clk_i, rst_ni, load_req, !busy, "load set busy")

  // A result follows directly on the MAC cycle
  `U2I4DL_ASSERT_NOW(a_result_after_mac, clk_i, rst_ni, result_valid_o, mac_done, "stray result")

  // Strobes are single pulses
  `U2I4DL_ASSERT_NEXT(a_strobe_one, clk_i, rst_ni, result_valid_o, !result_valid_o, "long strobe")

endmodule

bind u2_i4_dense_layer_dot_product_top u2i4dl_checker i_u2i4dl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o)
);

### sim/u2_i4_dense_layer_dot_product_checker.sv
// Checker: watches request, configuration and result channels, predicts and compares neuron sums
`timescale 1ns / 100ps

module u2_i4_dense_layer_dot_product_checker #(
  parameter int MAX_VECTOR_LENGTH = 1024,
  parameter int MAX_NEURONS       = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                cmd_i,
  input  logic [u2i4dl_pkg::ACT_INDEX_W-1:0]  act_index_i,
  input  logic [u2i4dl_pkg::PAYLOAD_W-1:0]    payload_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [u2i4dl_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                                result_valid_o,
  input  logic signed [u2i4dl_pkg::SUM_W-1:0] neuron_sum_o,
  input  logic [u2i4dl_pkg::NEURON_IDX_W-1:0] neuron_index_o,
  input  logic                                last_neuron_o,
  output int unsigned                         mismatches_o,
  output int unsigned                         sums_pending_o
);

  localparam int STORE_DEPTH = MAX_VECTOR_LENGTH / 4;

  typedef struct packed {
    logic signed [u2i4dl_pkg::SUM_W-1:0] sum;
    logic [u2i4dl_pkg::NEURON_IDX_W-1:0] index;
    logic                                last;
  } neuron_result_t;

  // Mirror of the layer state
  logic [u2i4dl_pkg::ACT_BYTE_W-1:0] act_bytes [STORE_DEPTH];
  logic [u2i4dl_pkg::SUM_W-1:0]      partial_sum;
  int unsigned                       word_pos;
  int unsigned                       neuron_pos;
  logic [u2i4dl_pkg::CFG_W-1:0]      vec_length;
  logic [u2i4dl_pkg::CFG_W-1:0]      neuron_total;
  neuron_result_t                    sums_due [$];
  int unsigned                       mismatches;

  // Weight words per neuron: length in fours, clamped to the store
  function automatic int unsigned words_per_neuron(logic [u2i4dl_pkg::CFG_W-1:0] len);
    int unsigned w;
    w = len >> 2;
    if (w < 1) w = 1;
    if (w > STORE_DEPTH) w = STORE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned neurons_in_layer(logic [u2i4dl_pkg::CFG_W-1:0] cnt);
    int unsigned n;
    n = cnt;
    if (n < 1) n = 1;
    if (n > MAX_NEURONS) n = MAX_NEURONS;
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    neuron_result_t due;
    logic [u2i4dl_pkg::ACT_BYTE_W-1:0] acts;
    int act_val;
    int wgt_val;
    int prod;
    if (!rst_ni) begin
      partial_sum  = '0;
      word_pos     = 0;
      neuron_pos   = 0;
      vec_length   = u2i4dl_pkg::VECTOR_LENGTH_RST;
      neuron_total = u2i4dl_pkg::NEURON_COUNT_RST;
      sums_due.delete();
    end else begin
      // Result strobe: compare with the oldest sum due
      if (result_valid_o) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result: sum %0d index %0d last %0d",
                 neuron_sum_o, neuron_index_o, last_neuron_o);
          mismatches++;
        end else begin
          due = sums_due.pop_front();
          if (neuron_sum_o !== due.sum) begin
            $error("neuron_sum: expected %0d, actual %0d", due.sum, neuron_sum_o);
            mismatches++;
          end
          if (neuron_index_o !== due.index) begin
            $error("neuron_index: expected %0d, actual %0d", due.index, neuron_index_o);
            mismatches++;
          end
          if (last_neuron_o !== due.last) begin
            $error("last_neuron: expected %0d, actual %0d", due.last, last_neuron_o);
            mismatches++;
          end
        end
      end

      // Accepted request
      if (start && !busy) begin
        if (cmd_i == u2i4dl_pkg::CMD_LOAD_ACT) begin
          if (act_index_i < STORE_DEPTH) act_bytes[act_index_i] = payload_i[7:0];
        end else begin
          acts = (word_pos < STORE_DEPTH) ? act_bytes[word_pos] : '0;
          // four unsigned 2-bit activations times signed nibbles, low first
          for (int k = 0; k < 4; k++) begin
            act_val     = acts[2*k +: 2];
            wgt_val     = $signed(payload_i[4*k +: 4]);
            prod        = act_val * wgt_val;
            partial_sum = partial_sum + prod[u2i4dl_pkg::SUM_W-1:0];
          end
          word_pos++;
          if (word_pos >= words_per_neuron(vec_length)) begin
            due.last  = (neuron_pos + 1 >= neurons_in_layer(neuron_total));
            due.sum   = partial_sum;
            due.index = neuron_pos[u2i4dl_pkg::NEURON_IDX_W-1:0];
            sums_due.push_back(due);
            partial_sum = '0;
            word_pos    = 0;
            neuron_pos  = due.last ? 0 : neuron_pos + 1;
          end
        end
      end

      // Register write; progress is kept
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          u2i4dl_pkg::REG_VECTOR_LENGTH: vec_length = cfg_data_i;
          u2i4dl_pkg::REG_NEURON_COUNT:  neuron_total = cfg_data_i;
          default: ;
        endcase
      end
    end
    mismatches_o   <= mismatches;
    sums_pending_o <= sums_due.size();
  end

endmodule

### sim/u2_i4_dense_layer_dot_product_top_tb.sv
// Testbench top: clock, reset, request and register stimulus, verdict
`timescale 1ns / 100ps

module u2_i4_dense_layer_dot_product_top_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 4;

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  logic                                cmd_i;
  logic [u2i4dl_pkg::ACT_INDEX_W-1:0]  act_index_i;
  logic [u2i4dl_pkg::PAYLOAD_W-1:0]    payload_i;
  logic                                cfg_valid_i;
  logic                                cfg_ready_o;
  logic                                cfg_index_i;
  logic [u2i4dl_pkg::CFG_W-1:0]        cfg_data_i;
  logic                                result_valid_o;
  logic signed [u2i4dl_pkg::SUM_W-1:0] neuron_sum_o;
  logic [u2i4dl_pkg::NEURON_IDX_W-1:0] neuron_index_o;
  logic                                last_neuron_o;

  int unsigned mismatches;
  int unsigned sums_pending;
  int unsigned idle_pct;
  int unsigned cycle_count = 0;
  int unsigned random_items;

  always #1 clk_i = ~clk_i;

  u2_i4_dense_layer_dot_product_top dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .act_index_i, .payload_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .neuron_sum_o, .neuron_index_o, .last_neuron_o
  );

  u2_i4_dense_layer_dot_product_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .act_index_i, .payload_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .result_valid_o, .neuron_sum_o, .neuron_index_o, .last_neuron_o,
    .mismatches_o(mismatches), .sums_pending_o(sums_pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("u2_i4_dense_layer_dot_product_top_tb failed");
      $finish;
    end
  end

  // One request; entered and left at a falling edge. Optional random gap, or a
  // drain that holds off until every sum due has come out.
  task automatic send_request(input logic cmd, input logic [7:0] slot,
                              input logic [15:0] data, input bit drain);
    if (drain || $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i);
      while ((drain && sums_pending != 0) || $urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    act_index_i <= slot;
    payload_i   <= data;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Wait for an idle block, then write both registers back to back
  task automatic configure_layer(input logic [10:0] len, input logic [10:0] cnt);
    start <= 1'b0;
    do @(negedge clk_i); while (sums_pending != 0);
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= u2i4dl_pkg::REG_VECTOR_LENGTH;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i <= u2i4dl_pkg::REG_NEURON_COUNT;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [10:0] pick_length();
    case ($urandom_range(19))
      0:       return 11'($urandom_range(3));
      1:       return 11'd2047;
      2:       return 11'd1024;
      default: return 11'($urandom_range(1, 16) * 4 + $urandom_range(3));
    endcase
  endfunction

  function automatic logic [10:0] pick_count();
    case ($urandom_range(9))
      0:       return 11'd0;
      1:       return 11'd2047;
      2:       return 11'd1;
      default: return 11'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [15:0] pick_weights();
    case ($urandom_range(11))
      0:       return 16'h8888;
      1:       return 16'h7777;
      2:       return 16'hffff;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = u2i4dl_pkg::CMD_LOAD_ACT;
    act_index_i = '0;
    payload_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = u2i4dl_pkg::REG_VECTOR_LENGTH;
    cfg_data_i  = '0;
    idle_pct    = 12;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole store with full-scale activations so no read hits an
    // unwritten slot
    for (int s = 0; s < 256; s++)
      send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'(s), {8'($urandom), 8'hff}, 1'b0);

    // Directed: reset length gives one word per neuron, one neuron per layer
    send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'd0,   16'hffff, 1'b0);
    send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'd255, 16'h00aa, 1'b0);
    send_request(u2i4dl_pkg::CMD_WEIGHT,   8'd0,   16'h8888, 1'b0);
    send_request(u2i4dl_pkg::CMD_WEIGHT,   8'd255, 16'h7777, 1'b0);
    send_request(u2i4dl_pkg::CMD_WEIGHT,   8'd0,   16'hffff, 1'b0);
    send_request(u2i4dl_pkg::CMD_WEIGHT,   8'd0,   16'h0000, 1'b0);
    // activations 0,1,2,3 against mixed-sign weights
    send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'd0,   16'h5ae4, 1'b0);
    send_request(u2i4dl_pkg::CMD_WEIGHT,   8'd0,   16'h8421, 1'b1);
    send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'd0,   16'hff00, 1'b0);
    send_request(u2i4dl_pkg::CMD_WEIGHT,   8'd0,   16'h8888, 1'b0);
    // length with low bits set, three neurons
    configure_layer(11'd7, 11'd3);
    send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'd0,   16'h00ff, 1'b0);
    repeat (4) send_request(u2i4dl_pkg::CMD_WEIGHT, 8'($urandom), pick_weights(), 1'b0);
    // zero registers are clamped to one
    configure_layer(11'd0, 11'd0);
    repeat (2) send_request(u2i4dl_pkg::CMD_WEIGHT, 8'($urandom), pick_weights(), 1'b0);

    // Full length at full scale: most negative sum
    configure_layer(11'd1024, 11'd1);
    send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'd255, 16'h00ff, 1'b0);
    repeat (256) send_request(u2i4dl_pkg::CMD_WEIGHT, 8'($urandom), 16'h8888, 1'b0);

    // Over-range neuron count: the index climbs
    configure_layer(11'd4, 11'd2047);
    repeat (24) send_request(u2i4dl_pkg::CMD_WEIGHT, 8'($urandom), 16'($urandom), 1'b0);

    // Over-range length, left mid-neuron for the next setting
    configure_layer(11'd2047, 11'd1024);
    repeat (10) send_request(u2i4dl_pkg::CMD_WEIGHT, 8'($urandom), pick_weights(), 1'b0);

    // Random phases: new layer shape each time, mostly weight words
    random_items = 0;
    while (random_items < 290) begin
      configure_layer(pick_length(), pick_count());
      repeat ($urandom_range(40, 90)) begin
        idle_pct = (random_items < 97) ? 12 : (random_items < 194) ? 74 : 0;
        if ($urandom_range(99) < 15)
          send_request(u2i4dl_pkg::CMD_LOAD_ACT, 8'($urandom), 16'($urandom), 1'b0);
        else
          send_request(u2i4dl_pkg::CMD_WEIGHT, 8'($urandom), pick_weights(),
                       $urandom_range(59) == 0);
        random_items++;
      end
    end

    // Drain and settle
    start <= 1'b0;
    do @(negedge clk_i); while (sums_pending != 0);
    repeat (SETTLE * 2) @(negedge clk_i);
    if (mismatches == 0 && sums_pending == 0)
      $display("u2_i4_dense_layer_dot_product_top_tb passed");
    else
      $display("u2_i4_dense_layer_dot_product_top_tb failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/u2i4dl_pkg.sv
sv/u2i4dl_ctrl.sv
sv/u2i4dl_datapath.sv
sv/u2_i4_dense_layer_dot_product_top.sv
sv/u2i4dl_checker.sv
sim/u2_i4_dense_layer_dot_product_checker.sv
sim/u2_i4_dense_layer_dot_product_top_tb.sv
